@@ rtl/sfpd_pkg.sv @@
// Package for the SYN frame parity deframer.
// Holds widths, reset values, register codes and the structs shared by the modules.
// No dependencies.
package sfpd_pkg;

    localparam int CHAR_W   = 7;
    localparam int BITPOS_W = 3;
    localparam int POS_W    = 8;

    localparam logic [CHAR_W-1:0]   SYNC_RESET  = 7'd22;
    localparam logic [POS_W-1:0]    FRAME_RESET = 8'd67;
    localparam logic [POS_W-1:0]    MIN_FRAME   = 8'd4;
    localparam logic [POS_W-1:0]    HDR_CHARS   = 8'd3;
    localparam logic [BITPOS_W-1:0] LAST_BIT    = 3'd7;

    // Register selects, taken from address bit 2.
    localparam logic REG_SYNC  = 1'b0;
    localparam logic REG_FRAME = 1'b1;

    typedef struct packed {
        logic              done;
        logic [CHAR_W-1:0] value;
        logic              odd;
    } t_char;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] data_char;
        logic              parity_error;
        logic              frame_error;
        logic              last_in_frame;
    } t_result;

endpackage

@@ rtl/sfpd_char_asm.sv @@
// Character assembler: shifts line bits (a parity bit, then seven data bits) into 7-bit characters and tracks parity.
// Depends on sfpd_pkg.
module sfpd_char_asm (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_bit,
    output sfpd_pkg::t_char o_char
);

    logic [sfpd_pkg::CHAR_W-1:0]   r_shift, n_shift;
    logic                          r_par, n_par;
    logic [sfpd_pkg::BITPOS_W-1:0] r_bitpos, n_bitpos;

    always_comb begin
        n_shift  = r_shift;
        n_par    = r_par;
        n_bitpos = r_bitpos;
        if (i_en) begin
            if (r_bitpos == '0) begin
                // Parity bit opens the character.
                n_par    = i_bit;
                n_shift  = '0;
                n_bitpos = r_bitpos + 1'b1;
            end else begin
                n_par    = r_par ^ i_bit;
                n_shift  = {i_bit, r_shift[sfpd_pkg::CHAR_W-1:1]};
                n_bitpos = (r_bitpos == sfpd_pkg::LAST_BIT) ? '0 : r_bitpos + 1'b1;
            end
        end
    end

    assign o_char.done  = i_en && (r_bitpos == sfpd_pkg::LAST_BIT);
    assign o_char.value = {i_bit, r_shift[sfpd_pkg::CHAR_W-1:1]};
    assign o_char.odd   = r_par ^ i_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= '0;
            r_par    <= 1'b0;
            r_bitpos <= '0;
        end else begin
            r_shift  <= n_shift;
            r_par    <= n_par;
            r_bitpos <= n_bitpos;
        end
    end

endmodule

@@ rtl/sfpd_frame_ctl.sv @@
// Frame control: checks sync and length characters and classifies data characters.
// Depends on sfpd_pkg.
module sfpd_frame_ctl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfpd_pkg::t_char             i_char,
    input  logic [sfpd_pkg::CHAR_W-1:0] i_sync_code,
    input  logic [sfpd_pkg::POS_W-1:0]  i_frame_bytes,
    output sfpd_pkg::t_result           o_result,
    output logic                        o_halted
);

    logic [sfpd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [sfpd_pkg::CHAR_W-1:0] r_len, n_len;
    logic                        r_halted, n_halted;
    logic [sfpd_pkg::POS_W-1:0]  eff;
    logic [sfpd_pkg::POS_W:0]    data_end;
    logic [sfpd_pkg::POS_W:0]    next_pos;

    always_comb begin
        eff      = (i_frame_bytes < sfpd_pkg::MIN_FRAME) ? sfpd_pkg::MIN_FRAME : i_frame_bytes;
        data_end = {1'b0, sfpd_pkg::HDR_CHARS} + {2'b00, r_len};
        next_pos = {1'b0, r_pos} + 9'd1;

        n_pos    = r_pos;
        n_len    = r_len;
        n_halted = r_halted;
        o_result = '0;

        if (i_char.done) begin
            if (r_pos < 8'd2) begin
                if (i_char.value != i_sync_code) begin
                    n_halted             = 1'b1;
                    o_result.valid       = 1'b1;
                    o_result.frame_error = 1'b1;
                end
            end else if (r_pos == 8'd2) begin
                if ({1'b0, i_char.value} > (eff - sfpd_pkg::HDR_CHARS)) begin
                    n_halted             = 1'b1;
                    o_result.valid       = 1'b1;
                    o_result.frame_error = 1'b1;
                end else begin
                    n_len = i_char.value;
                end
            end else if ({1'b0, r_pos} < data_end) begin
                o_result.valid         = 1'b1;
                o_result.data_char     = i_char.value;
                o_result.parity_error  = !i_char.odd;
                o_result.last_in_frame = ({1'b0, r_pos} == data_end - 9'd1);
            end
            // The frame ends once the next index would reach the effective size.
            n_pos = (next_pos >= {1'b0, eff}) ? '0 : next_pos[sfpd_pkg::POS_W-1:0];
        end
    end

    assign o_halted = r_halted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_len    <= '0;
            r_halted <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_halted <= n_halted;
        end
    end

endmodule

@@ rtl/sfpd_out_reg.sv @@
// Output register: holds one result until the downstream side takes it.
// Depends on sfpd_pkg.
module sfpd_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfpd_pkg::t_result           i_result,
    input  logic                        i_load_ok,
    input  logic                        i_tready,
    output logic                        o_can_load,
    output logic                        o_tvalid,
    output logic [sfpd_pkg::CHAR_W-1:0] o_data_char,
    output logic                        o_parity_error,
    output logic                        o_frame_error,
    output logic                        o_last_in_frame
);

    logic                        r_valid;
    logic [sfpd_pkg::CHAR_W-1:0] r_data;
    logic                        r_perr;
    logic                        r_ferr;
    logic                        r_last;
    logic                        load;

    assign o_can_load = !r_valid || i_tready;
    assign load       = i_load_ok && i_result.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && load) begin
            r_data <= i_result.data_char;
            r_perr <= i_result.parity_error;
            r_ferr <= i_result.frame_error;
            r_last <= i_result.last_in_frame;
        end
    end

    assign o_tvalid        = r_valid;
    assign o_data_char     = r_data;
    assign o_parity_error  = r_perr;
    assign o_frame_error   = r_ferr;
    assign o_last_in_frame = r_last;

endmodule

@@ rtl/syn_frame_parity_deframer.sv @@
// SYN framed deframer with odd parity, one line bit per request.
// A completed character's result appears in the cycle after its last bit is accepted.
// Throughput: one bit per cycle; the input stalls only while the output register is full
// and not being taken.
// Reset (synchronous, active low) clears the bit and character counters, the halt flag,
// the output valid and sets sync_code to 22 and frame_bytes to 67.
module syn_frame_parity_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] bit_req, [7:1] zero
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] data_char, [7] zero
    output logic [1:0]  m_axis_tuser,   // [0] parity_error, [1] frame_error
    output logic        m_axis_tlast    // last_in_frame
);

    logic [sfpd_pkg::CHAR_W-1:0] r_sync_code;
    logic [sfpd_pkg::POS_W-1:0]  r_frame_bytes;
    logic                        accept;
    logic                        halted;
    logic                        can_load;
    sfpd_pkg::t_char             chr;
    sfpd_pkg::t_result           result;
    logic [sfpd_pkg::CHAR_W-1:0] out_char;
    logic                        out_perr;
    logic                        out_ferr;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_code   <= sfpd_pkg::SYNC_RESET;
            r_frame_bytes <= sfpd_pkg::FRAME_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                sfpd_pkg::REG_SYNC:  r_sync_code   <= pwdata[sfpd_pkg::CHAR_W-1:0];
                sfpd_pkg::REG_FRAME: r_frame_bytes <= pwdata[sfpd_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            sfpd_pkg::REG_SYNC:  prdata = {25'd0, r_sync_code};
            sfpd_pkg::REG_FRAME: prdata = {24'd0, r_frame_bytes};
            default:             prdata = '0;
        endcase
    end

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sfpd_char_asm u_char_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept && !halted),
        .i_bit   (s_axis_tdata[0]),
        .o_char  (chr)
    );

    sfpd_frame_ctl u_frame_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char        (chr),
        .i_sync_code   (r_sync_code),
        .i_frame_bytes (r_frame_bytes),
        .o_result      (result),
        .o_halted      (halted)
    );

    sfpd_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_result        (result),
        .i_load_ok       (accept),
        .i_tready        (m_axis_tready),
        .o_can_load      (can_load),
        .o_tvalid        (m_axis_tvalid),
        .o_data_char     (out_char),
        .o_parity_error  (out_perr),
        .o_frame_error   (out_ferr),
        .o_last_in_frame (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_char};
    assign m_axis_tuser = {out_ferr, out_perr};

endmodule

@@ rtl/sfpd_checker.sv @@
// Port-level checks for the SYN frame parity deframer, bound to the top level.
// Depends only on the top level's ports.
module sfpd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A frame error result carries no character, parity flag or frame end.
    a_ferr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata == 8'd0 && !m_axis_tuser[0] && !m_axis_tlast)
        else $error("frame error result not clean");

    // Once the frame error is taken the block stays silent.
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |=> !m_axis_tvalid)
        else $error("result after frame error");

    // The input only stalls behind a full output register.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind syn_frame_parity_deframer sfpd_checker u_sfpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
